/* hdl/ttf_pkg.sv */
`timescale 1ns / 1ps
package ttf_pkg;

    localparam int VertexDepthDef = 4096;
    localparam int IdxW = 12;
    localparam int PosW = 32;
    localparam int NrmW = 16;
    localparam int OutW = 16;

    localparam logic KindWrite = 1'b0;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_DELTA, S_MUL, S_RAW,
        S_NORM, S_SQ, S_SQRT, S_DIVLD, S_DIV, S_XMUL, S_XOUT
    } t_state;

    // one vertex store entry
    typedef struct packed {
        logic signed [PosW-1:0] px;
        logic signed [PosW-1:0] py;
        logic signed [PosW-1:0] pz;
        logic signed [NrmW-1:0] nz;
        logic signed [NrmW-1:0] ny;
        logic signed [NrmW-1:0] nx;
        logic signed [PosW-1:0] tu;
        logic signed [PosW-1:0] tv;
    } t_vert;

    // difference clamped to signed 32 bits
    function automatic logic signed [PosW-1:0] sat_diff(input logic signed [PosW-1:0] a,
                                                        input logic signed [PosW-1:0] b);
        logic signed [PosW:0] d;
        d = (PosW+1)'(a) - (PosW+1)'(b);
        if (d[PosW] != d[PosW-1])
            sat_diff = d[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
        else
            sat_diff = d[PosW-1:0];
    endfunction

    // rounded Q2.14 cross term from two registered products
    function automatic logic signed [OutW-1:0] xterm(input logic signed [31:0] p,
                                                     input logic signed [31:0] q);
        logic signed [33:0] s;
        logic signed [19:0] r;
        s = 34'(p) - 34'(q) + 34'sd8192;
        r = 20'(s >>> 14);
        if (r > 20'sd32767)
            xterm = 16'sh7FFF;
        else if (r < -20'sd32768)
            xterm = 16'sh8000;
        else
            xterm = r[15:0];
    endfunction

endpackage

/* hdl/triangle_tangent_frame_core.sv */
`timescale 1ns / 1ps
// Vertex write: busy stays low. Triangle: busy while the three corners are read from the store,
// 8 products are formed on one shared 32x32 multiplier, the tangent is normalized by
// power-of-two shifts, squared, put through a 32-step square root and divided per component;
// a zero UV determinant or a zero-length tangent skips to the output. Then 3 result beats,
// each a single-cycle o_done strobe that the receiver cannot stall.
// Reset (i_rst_n low at a clock edge) returns the sequencer to idle; store undefined until written.
module triangle_tangent_frame_core #(
    parameter int VERTEX_DEPTH = ttf_pkg::VertexDepthDef
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_kind,
    input  logic        [ttf_pkg::IdxW-1:0]  i_vertex_index,
    input  logic signed [ttf_pkg::PosW-1:0]  i_pos_x,
    input  logic signed [ttf_pkg::PosW-1:0]  i_pos_y,
    input  logic signed [ttf_pkg::PosW-1:0]  i_pos_z,
    input  logic signed [ttf_pkg::NrmW-1:0]  i_norm_x,
    input  logic signed [ttf_pkg::NrmW-1:0]  i_norm_y,
    input  logic signed [ttf_pkg::NrmW-1:0]  i_norm_z,
    input  logic signed [ttf_pkg::PosW-1:0]  i_tex_u,
    input  logic signed [ttf_pkg::PosW-1:0]  i_tex_v,
    input  logic        [ttf_pkg::IdxW-1:0]  i_second_corner,
    input  logic        [ttf_pkg::IdxW-1:0]  i_third_corner,
    output logic                             o_done,
    output logic        [ttf_pkg::IdxW-1:0]  o_corner_index,
    output logic signed [ttf_pkg::OutW-1:0]  o_tangent_x,
    output logic signed [ttf_pkg::OutW-1:0]  o_tangent_y,
    output logic signed [ttf_pkg::OutW-1:0]  o_tangent_z,
    output logic signed [ttf_pkg::OutW-1:0]  o_bitangent_x,
    output logic signed [ttf_pkg::OutW-1:0]  o_bitangent_y,
    output logic signed [ttf_pkg::OutW-1:0]  o_bitangent_z,
    output logic                             o_degenerate,
    output logic                             o_last_corner
);
    import ttf_pkg::*;

    localparam int AW = $clog2(VERTEX_DEPTH);
    localparam logic [16:0] DepthL = 17'(VERTEX_DEPTH);

    t_state r_state, n_state;

    // vertex store
    t_vert  mem [VERTEX_DEPTH];
    t_vert  r_rdata;
    t_vert  w_wvert;
    logic   w_we;
    logic [AW-1:0] w_waddr, w_raddr;

    // triangle working set
    logic        [IdxW-1:0] r_idx [3];
    logic                   r_inr [3];
    logic signed [PosW-1:0] r_pos [3][3];
    logic signed [NrmW-1:0] r_nrm [3][3];
    logic signed [PosW-1:0] r_tu [3];
    logic signed [PosW-1:0] r_tv [3];
    logic signed [PosW-1:0] r_du1, r_dv1, r_du2, r_dv2;
    logic signed [PosW-1:0] r_e1 [3];
    logic signed [PosW-1:0] r_e2 [3];
    logic signed [63:0]     r_prod [8];
    logic signed [63:0]     r_raw [3];
    logic [63:0]            r_sq, r_sum, r_sqv, r_root, r_bit;
    logic [31:0]            r_len;
    logic [47:0]            r_rem;
    logic [15:0]            r_q;
    logic [1:0]             r_dcomp;
    logic [4:0]             r_cnt;
    logic signed [OutW-1:0] r_t [3];
    logic                   r_degen;
    logic signed [31:0]     r_xp [6];
    logic [1:0]             r_k;
    logic                   r_done;

    logic w_accept;
    logic [1:0] w_cap;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    // store write from the input beat, read address from the sequencer
    always_comb begin
        w_wvert.px = i_pos_x;
        w_wvert.py = i_pos_y;
        w_wvert.pz = i_pos_z;
        w_wvert.nx = i_norm_x;
        w_wvert.ny = i_norm_y;
        w_wvert.nz = i_norm_z;
        w_wvert.tu = i_tex_u;
        w_wvert.tv = i_tex_v;
        w_we    = w_accept && (i_kind == KindWrite) && (17'(i_vertex_index) < DepthL);
        w_waddr = AW'(i_vertex_index);
        case (r_state)
            S_RD1:   w_raddr = AW'(r_idx[1]);
            S_RD2:   w_raddr = AW'(r_idx[2]);
            default: w_raddr = AW'(r_idx[0]);
        endcase
    end

    // writes only happen while idle, read data is only captured while busy: no overlap
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wvert;
        end
        r_rdata <= mem[w_raddr];
    end

    // shared multiplier
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_mp;
    logic [63:0] w_mag [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_raw[i][63] ? 64'(-r_raw[i]) : 64'(r_raw[i]);
        end
        w_ma = r_du1;
        w_mb = r_dv2;
        if (r_state == S_SQ) begin
            case (r_cnt)
                5'd0:    w_ma = 32'(w_mag[0]);
                5'd1:    w_ma = 32'(w_mag[1]);
                default: w_ma = 32'(w_mag[2]);
            endcase
            w_mb = w_ma;
        end else begin
            case (r_cnt)
                5'd0:    begin w_ma = r_du1;   w_mb = r_dv2; end
                5'd1:    begin w_ma = r_du2;   w_mb = r_dv1; end
                5'd2:    begin w_ma = r_e1[0]; w_mb = r_dv2; end
                5'd3:    begin w_ma = r_e1[1]; w_mb = r_dv2; end
                5'd4:    begin w_ma = r_e1[2]; w_mb = r_dv2; end
                5'd5:    begin w_ma = r_e2[0]; w_mb = r_dv1; end
                5'd6:    begin w_ma = r_e2[1]; w_mb = r_dv1; end
                default: begin w_ma = r_e2[2]; w_mb = r_dv1; end
            endcase
        end
        w_mp = 64'(w_ma) * 64'(w_mb);
    end

    // normalize, root and divide step logic
    logic w_big, w_small, w_zero, w_det_zero, w_det_neg;
    logic [63:0] w_trial;
    logic [47:0] w_dsh;
    logic [15:0] w_qn;
    logic [63:0] w_dmag;

    always_comb begin
        w_big   = |w_mag[0][63:30] || |w_mag[1][63:30] || |w_mag[2][63:30];
        w_small = !(|w_mag[0][63:29]) && !(|w_mag[1][63:29]) && !(|w_mag[2][63:29]);
        w_zero  = (w_mag[0] == 64'd0) && (w_mag[1] == 64'd0) && (w_mag[2] == 64'd0);
        w_det_zero = (r_prod[0] == r_prod[1]);
        w_det_neg  = (r_prod[0] < r_prod[1]);
        w_trial = r_root + r_bit;
        w_dsh   = 48'(r_len) << r_cnt[3:0];
        w_qn    = r_q;
        if (r_rem >= w_dsh) begin
            w_qn = r_q | (16'd1 << r_cnt[3:0]);
        end
        case (r_dcomp)
            2'd0:    w_dmag = w_mag[0];
            2'd1:    w_dmag = w_mag[1];
            default: w_dmag = w_mag[2];
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept && i_kind != KindWrite) n_state = S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_RD3;
            S_RD3:   n_state = S_DELTA;
            S_DELTA: n_state = S_MUL;
            S_MUL:   if (r_cnt == 5'd7) n_state = S_RAW;
            S_RAW:   n_state = w_det_zero ? S_XMUL : S_NORM;
            S_NORM: begin
                if (w_zero)
                    n_state = S_XMUL;
                else if (!w_big && !w_small)
                    n_state = S_SQ;
            end
            S_SQ:    if (r_cnt == 5'd3) n_state = S_SQRT;
            S_SQRT:  if (r_cnt == 5'd31) n_state = S_DIVLD;
            S_DIVLD: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == 5'd0)
                    n_state = (r_dcomp == 2'd2) ? S_XMUL : S_DIVLD;
            end
            S_XMUL:  n_state = S_XOUT;
            S_XOUT:  n_state = (r_k == 2'd2) ? S_IDLE : S_XMUL;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 5'd0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_XOUT);
            if (r_state != n_state) begin
                r_cnt <= (n_state == S_DIV) ? 5'd15 : 5'd0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt - 5'd1;
            end else begin
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    assign o_done = r_done;

    assign w_cap = (r_state == S_RD1) ? 2'd0 : (r_state == S_RD2) ? 2'd1 : 2'd2;

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx[0] <= i_vertex_index;
                r_idx[1] <= i_second_corner;
                r_idx[2] <= i_third_corner;
                r_inr[0] <= 17'(i_vertex_index) < DepthL;
                r_inr[1] <= 17'(i_second_corner) < DepthL;
                r_inr[2] <= 17'(i_third_corner) < DepthL;
                r_degen  <= 1'b0;
                r_k      <= 2'd0;
                r_dcomp  <= 2'd0;
                r_sum    <= 64'd0;
                r_sqv    <= 64'd0;
                r_root   <= 64'd0;
                r_bit    <= 64'd1 << 62;
                for (int i = 0; i < 3; i++) r_t[i] <= '0;
            end
            S_RD1, S_RD2, S_RD3: begin
                // out-of-range corners read as zero
                r_pos[w_cap][0] <= r_inr[w_cap] ? r_rdata.px : '0;
                r_pos[w_cap][1] <= r_inr[w_cap] ? r_rdata.py : '0;
                r_pos[w_cap][2] <= r_inr[w_cap] ? r_rdata.pz : '0;
                r_nrm[w_cap][0] <= r_inr[w_cap] ? r_rdata.nx : '0;
                r_nrm[w_cap][1] <= r_inr[w_cap] ? r_rdata.ny : '0;
                r_nrm[w_cap][2] <= r_inr[w_cap] ? r_rdata.nz : '0;
                r_tu[w_cap]     <= r_inr[w_cap] ? r_rdata.tu : '0;
                r_tv[w_cap]     <= r_inr[w_cap] ? r_rdata.tv : '0;
            end
            S_DELTA: begin
                r_du1 <= sat_diff(r_tu[1], r_tu[0]);
                r_dv1 <= sat_diff(r_tv[1], r_tv[0]);
                r_du2 <= sat_diff(r_tu[2], r_tu[0]);
                r_dv2 <= sat_diff(r_tv[2], r_tv[0]);
                for (int i = 0; i < 3; i++) begin
                    r_e1[i] <= sat_diff(r_pos[1][i], r_pos[0][i]);
                    r_e2[i] <= sat_diff(r_pos[2][i], r_pos[0][i]);
                end
            end
            S_MUL: r_prod[r_cnt[2:0]] <= w_mp;
            S_RAW: begin
                r_degen <= w_det_zero;
                for (int i = 0; i < 3; i++) begin
                    if (w_det_neg)
                        r_raw[i] <= (r_prod[5+i] >>> 1) - (r_prod[2+i] >>> 1);
                    else
                        r_raw[i] <= (r_prod[2+i] >>> 1) - (r_prod[5+i] >>> 1);
                end
            end
            S_NORM: begin
                // one power-of-two step per cycle toward [2^29, 2^30)
                r_degen <= w_zero;
                for (int i = 0; i < 3; i++) begin
                    if (w_big)
                        r_raw[i] <= r_raw[i] >>> 1;
                    else if (w_small)
                        r_raw[i] <= r_raw[i] <<< 1;
                end
            end
            S_SQ: begin
                r_sq <= 64'(w_mp);
                if (r_cnt != 5'd0) r_sum <= r_sum + r_sq;
                r_sqv <= r_sum + r_sq;
            end
            S_SQRT: begin
                // one result bit per cycle
                if (r_sqv >= w_trial) begin
                    r_sqv  <= r_sqv - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_cnt == 5'd31) begin
                    if (r_sqv >= w_trial) r_len <= 32'((r_root >> 1) + r_bit);
                    else r_len <= 32'(r_root >> 1);
                end
            end
            S_DIVLD: begin
                r_rem <= (48'(w_dmag[29:0]) << 14) + 48'(r_len >> 1);
                r_q   <= 16'd0;
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (r_rem >= w_dsh) r_rem <= r_rem - w_dsh;
                r_q <= w_qn;
                if (r_cnt == 5'd0) begin
                    r_t[r_dcomp] <= r_raw[r_dcomp][63] ? -w_qn : w_qn;
                    r_dcomp <= r_dcomp + 2'd1;
                end
            end
            S_XMUL: begin
                r_xp[0] <= 32'(r_nrm[r_k][1]) * 32'(r_t[2]);
                r_xp[1] <= 32'(r_nrm[r_k][2]) * 32'(r_t[1]);
                r_xp[2] <= 32'(r_nrm[r_k][2]) * 32'(r_t[0]);
                r_xp[3] <= 32'(r_nrm[r_k][0]) * 32'(r_t[2]);
                r_xp[4] <= 32'(r_nrm[r_k][0]) * 32'(r_t[1]);
                r_xp[5] <= 32'(r_nrm[r_k][1]) * 32'(r_t[0]);
            end
            S_XOUT: begin
                o_corner_index <= r_idx[r_k];
                o_tangent_x    <= r_t[0];
                o_tangent_y    <= r_t[1];
                o_tangent_z    <= r_t[2];
                o_bitangent_x  <= xterm(r_xp[0], r_xp[1]);
                o_bitangent_y  <= xterm(r_xp[2], r_xp[3]);
                o_bitangent_z  <= xterm(r_xp[4], r_xp[5]);
                o_degenerate   <= r_degen;
                o_last_corner  <= (r_k == 2'd2);
                r_k            <= r_k + 2'd1;
            end
            default: ;
        endcase
    end

    // checks
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == S_XOUT)
        else $error("result beat without output step");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_degenerate) |->
            (o_tangent_x == 16'sd0 && o_tangent_y == 16'sd0 && o_tangent_z == 16'sd0))
        else $error("degenerate beat with nonzero tangent");
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KindWrite) |=> !busy)
        else $error("vertex write held the block busy");
    a_tri_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind != KindWrite) |=> busy)
        else $error("triangle not started");
    a_last_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_last_corner) |-> !busy)
        else $error("busy during last corner");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import ttf_pkg::*;

    localparam logic KindTriangle = ~KindWrite;
    localparam int   NumDirected  = 16;
    localparam int   NumRandom    = 395;
    localparam int   MaxReports   = 10;

    // one input beat
    typedef struct {
        logic                   kind;
        logic [IdxW-1:0]        idx;
        logic [IdxW-1:0]        c2;
        logic [IdxW-1:0]        c3;
        logic signed [PosW-1:0] px, py, pz, tu, tv;
        logic signed [NrmW-1:0] nx, ny, nz;
    } t_vbeat;

    // directed row: beat plus an optional hand-typed frame
    typedef struct {
        t_vbeat                 b;
        bit                     known;
        logic signed [OutW-1:0] tx, ty, tz, bx, by, bz;
        logic                   dg;
    } t_row;

    // one corner result
    typedef struct {
        logic [IdxW-1:0]        idx;
        logic signed [OutW-1:0] tx, ty, tz, bx, by, bz;
        logic                   dg;
        logic                   last;
    } t_corner;

    logic i_clk, i_rst_n, start, busy;
    logic i_kind;
    logic [IdxW-1:0] i_vertex_index, i_second_corner, i_third_corner;
    logic signed [PosW-1:0] i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v;
    logic signed [NrmW-1:0] i_norm_x, i_norm_y, i_norm_z;
    logic o_done, o_degenerate, o_last_corner;
    logic [IdxW-1:0] o_corner_index;
    logic signed [OutW-1:0] o_tangent_x, o_tangent_y, o_tangent_z;
    logic signed [OutW-1:0] o_bitangent_x, o_bitangent_y, o_bitangent_z;

    triangle_tangent_frame_core DUT (.*);

    // shadow vertex store
    logic signed [PosW-1:0] pos_x_mem [VertexDepthDef];
    logic signed [PosW-1:0] pos_y_mem [VertexDepthDef];
    logic signed [PosW-1:0] pos_z_mem [VertexDepthDef];
    logic signed [NrmW-1:0] nrm_x_mem [VertexDepthDef];
    logic signed [NrmW-1:0] nrm_y_mem [VertexDepthDef];
    logic signed [NrmW-1:0] nrm_z_mem [VertexDepthDef];
    logic signed [PosW-1:0] tex_u_mem [VertexDepthDef];
    logic signed [PosW-1:0] tex_v_mem [VertexDepthDef];
    bit                     filled    [VertexDepthDef];
    logic [IdxW-1:0]        filled_list[$];

    t_corner pending_corners[$];
    int      mismatches = 0;
    t_row    directed[NumDirected];
    logic [IdxW-1:0] hot_idx[16];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("testbench: errors");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic longint sat32(input longint d);
        if (d > 64'sd2147483647) return 64'sd2147483647;
        if (d < -64'sd2147483648) return -64'sd2147483648;
        return d;
    endfunction

    function automatic longint magn(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, bt;
        r  = 0;
        bt = 64'h4000_0000_0000_0000;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v -= r + bt;
                r  = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    // rounded Q2.14 cross product term, saturated
    function automatic logic signed [OutW-1:0] cross_q14(input longint a, input longint b,
                                                         input longint c, input longint d);
        longint r;
        r = (a * b - c * d + 8192) >>> 14;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[OutW-1:0];
    endfunction

    // tangent frame of one triangle, three corner results queued
    task automatic predict_frame(input logic [IdxW-1:0] i0, input logic [IdxW-1:0] i1,
                                 input logic [IdxW-1:0] i2);
        logic [IdxW-1:0] ix[3];
        longint du1, dv1, du2, dv2, pa, pb, e1, e2, m, q;
        longint r[3], t[3];
        longint unsigned sum, len;
        bit ok, done;
        t_corner c;
        ix = '{i0, i1, i2};
        du1 = sat32(longint'(tex_u_mem[i1]) - longint'(tex_u_mem[i0]));
        dv1 = sat32(longint'(tex_v_mem[i1]) - longint'(tex_v_mem[i0]));
        du2 = sat32(longint'(tex_u_mem[i2]) - longint'(tex_u_mem[i0]));
        dv2 = sat32(longint'(tex_v_mem[i2]) - longint'(tex_v_mem[i0]));
        pa = du1 * dv2;
        pb = du2 * dv1;
        t = '{0, 0, 0};
        ok = (pa != pb);
        if (ok) begin
            for (int k = 0; k < 3; k++) begin
                case (k)
                    0: begin
                        e1 = sat32(longint'(pos_x_mem[i1]) - longint'(pos_x_mem[i0]));
                        e2 = sat32(longint'(pos_x_mem[i2]) - longint'(pos_x_mem[i0]));
                    end
                    1: begin
                        e1 = sat32(longint'(pos_y_mem[i1]) - longint'(pos_y_mem[i0]));
                        e2 = sat32(longint'(pos_y_mem[i2]) - longint'(pos_y_mem[i0]));
                    end
                    default: begin
                        e1 = sat32(longint'(pos_z_mem[i1]) - longint'(pos_z_mem[i0]));
                        e2 = sat32(longint'(pos_z_mem[i2]) - longint'(pos_z_mem[i0]));
                    end
                endcase
                r[k] = ((e1 * dv2) >>> 1) - ((e2 * dv1) >>> 1);
                if (pa < pb) r[k] = -r[k];
            end
            // scale so the largest magnitude lands in [2^29, 2^30)
            done = 0;
            while (!done) begin
                m = magn(r[0]);
                if (magn(r[1]) > m) m = magn(r[1]);
                if (magn(r[2]) > m) m = magn(r[2]);
                if (m == 0) begin
                    ok = 0;
                    done = 1;
                end else if (m >= (64'sd1 << 30)) begin
                    for (int k = 0; k < 3; k++) r[k] = r[k] >>> 1;
                end else if (m < (64'sd1 << 29)) begin
                    for (int k = 0; k < 3; k++) r[k] = r[k] * 2;
                end else begin
                    done = 1;
                end
            end
            if (ok) begin
                sum = 0;
                for (int k = 0; k < 3; k++) sum += magn(r[k]) * magn(r[k]);
                len = int_sqrt(sum);
                for (int k = 0; k < 3; k++) begin
                    q = (magn(r[k]) * 16384 + len / 2) / len;
                    t[k] = (r[k] < 0) ? -q : q;
                end
            end
        end
        for (int k = 0; k < 3; k++) begin
            c.idx  = ix[k];
            c.tx   = t[0][OutW-1:0];
            c.ty   = t[1][OutW-1:0];
            c.tz   = t[2][OutW-1:0];
            c.bx   = cross_q14(nrm_y_mem[ix[k]], t[2], nrm_z_mem[ix[k]], t[1]);
            c.by   = cross_q14(nrm_z_mem[ix[k]], t[0], nrm_x_mem[ix[k]], t[2]);
            c.bz   = cross_q14(nrm_x_mem[ix[k]], t[1], nrm_y_mem[ix[k]], t[0]);
            c.dg   = ~ok;
            c.last = (k == 2);
            pending_corners = {pending_corners, c};
        end
    endtask

    // update the shadow store, or queue the frame of a triangle
    task automatic absorb_beat(input t_row rw);
        t_corner c;
        if (rw.b.kind == KindWrite) begin
            pos_x_mem[rw.b.idx] = rw.b.px;
            pos_y_mem[rw.b.idx] = rw.b.py;
            pos_z_mem[rw.b.idx] = rw.b.pz;
            nrm_x_mem[rw.b.idx] = rw.b.nx;
            nrm_y_mem[rw.b.idx] = rw.b.ny;
            nrm_z_mem[rw.b.idx] = rw.b.nz;
            tex_u_mem[rw.b.idx] = rw.b.tu;
            tex_v_mem[rw.b.idx] = rw.b.tv;
            if (!filled[rw.b.idx]) begin
                filled[rw.b.idx] = 1;
                filled_list = {filled_list, rw.b.idx};
            end
        end else if (rw.known) begin
            for (int k = 0; k < 3; k++) begin
                c.idx  = (k == 0) ? rw.b.idx : (k == 1) ? rw.b.c2 : rw.b.c3;
                c.tx   = rw.tx; c.ty = rw.ty; c.tz = rw.tz;
                c.bx   = rw.bx; c.by = rw.by; c.bz = rw.bz;
                c.dg   = rw.dg;
                c.last = (k == 2);
                pending_corners = {pending_corners, c};
            end
        end else begin
            predict_frame(rw.b.idx, rw.b.c2, rw.b.c3);
        end
    endtask

    // ---------------- stimulus helpers ----------------
    function automatic t_row wr_row(input logic [IdxW-1:0] idx,
                                    input logic signed [PosW-1:0] px, py, pz,
                                    input logic signed [NrmW-1:0] nx, ny, nz,
                                    input logic signed [PosW-1:0] tu, tv);
        t_row rw;
        rw = '{default: '0};
        rw.b = '{kind: KindWrite, idx: idx, c2: idx, c3: idx, px: px, py: py, pz: pz,
                 tu: tu, tv: tv, nx: nx, ny: ny, nz: nz};
        return rw;
    endfunction

    function automatic t_row tri_row(input logic [IdxW-1:0] a, b, c);
        t_row rw;
        rw = '{default: '0};
        rw.b.kind = KindTriangle;
        rw.b.idx = a;
        rw.b.c2 = b;
        rw.b.c3 = c;
        return rw;
    endfunction

    function automatic t_row tri_known(input logic [IdxW-1:0] a, b, c,
                                       input logic signed [OutW-1:0] tx, ty, tz, bx, by, bz,
                                       input logic dg);
        t_row rw;
        rw = tri_row(a, b, c);
        rw.known = 1;
        rw.tx = tx; rw.ty = ty; rw.tz = tz;
        rw.bx = bx; rw.by = by; rw.bz = bz;
        rw.dg = dg;
        return rw;
    endfunction

    function automatic logic signed [PosW-1:0] rand_q16();
        case ($urandom_range(0, 6))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return $urandom();
            4: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    function automatic logic signed [NrmW-1:0] rand_q14();
        case ($urandom_range(0, 4))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom());
            default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        endcase
    endfunction

    function automatic t_row rand_row();
        t_row rw;
        logic [IdxW-1:0] a;
        rw = '{default: '0};
        rw.b = '{kind: KindWrite, idx: IdxW'($urandom()), c2: IdxW'($urandom()),
                 c3: IdxW'($urandom()),
                 px: rand_q16(), py: rand_q16(), pz: rand_q16(), tu: rand_q16(),
                 tv: rand_q16(), nx: rand_q14(), ny: rand_q14(), nz: rand_q14()};
        if ($urandom_range(0, 9) < 4) begin
            // mostly rewrite a hot set so triangles see fresh vertices
            a = ($urandom_range(0, 3) == 0) ? IdxW'($urandom()) : hot_idx[$urandom_range(0, 15)];
            rw.b.idx = a;
        end else begin
            rw.b.kind = KindTriangle;
            rw.b.idx = filled_list[$urandom_range(0, filled_list.size() - 1)];
            rw.b.c2  = filled_list[$urandom_range(0, filled_list.size() - 1)];
            rw.b.c3  = filled_list[$urandom_range(0, filled_list.size() - 1)];
        end
        return rw;
    endfunction

    // drive one beat and hold it until accepted
    task automatic issue_beat(input t_row rw);
        start           <= 1'b1;
        i_kind          <= rw.b.kind;
        i_vertex_index  <= rw.b.idx;
        i_second_corner <= rw.b.c2;
        i_third_corner  <= rw.b.c3;
        i_pos_x <= rw.b.px; i_pos_y <= rw.b.py; i_pos_z <= rw.b.pz;
        i_norm_x <= rw.b.nx; i_norm_y <= rw.b.ny; i_norm_z <= rw.b.nz;
        i_tex_u <= rw.b.tu; i_tex_v <= rw.b.tv;
        do @(posedge i_clk); while (busy);
        absorb_beat(rw);
    endtask

    task automatic maybe_gap(input bit allow);
        if (allow && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // ---------------- result checking ----------------
    always @(posedge i_clk) begin
        t_corner c;
        if (i_rst_n && o_done) begin
            if (pending_corners.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReports)
                    $display("unexpected corner beat idx=%0d", o_corner_index);
            end else begin
                c = pending_corners.pop_front();
                if (o_corner_index !== c.idx || o_tangent_x !== c.tx || o_tangent_y !== c.ty ||
                    o_tangent_z !== c.tz || o_bitangent_x !== c.bx ||
                    o_bitangent_y !== c.by || o_bitangent_z !== c.bz ||
                    o_degenerate !== c.dg || o_last_corner !== c.last) begin
                    mismatches++;
                    if (mismatches <= MaxReports) begin
                        $display("mismatch exp idx=%0d t=(%0d,%0d,%0d) b=(%0d,%0d,%0d) dg=%b l=%b",
                                 c.idx, c.tx, c.ty, c.tz, c.bx, c.by, c.bz, c.dg, c.last);
                        $display("         got idx=%0d t=(%0d,%0d,%0d) b=(%0d,%0d,%0d) dg=%b l=%b",
                                 o_corner_index, o_tangent_x, o_tangent_y, o_tangent_z,
                                 o_bitangent_x, o_bitangent_y, o_bitangent_z,
                                 o_degenerate, o_last_corner);
                    end
                end
            end
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        int waited;
        i_rst_n = 1'b0; start = 1'b0; i_kind = KindWrite;
        i_vertex_index = '0; i_second_corner = '0; i_third_corner = '0;
        i_pos_x = '0; i_pos_y = '0; i_pos_z = '0;
        i_norm_x = '0; i_norm_y = '0; i_norm_z = '0; i_tex_u = '0; i_tex_v = '0;
        foreach (hot_idx[k]) hot_idx[k] = IdxW'($urandom());

        // unit square corner: tangent along x, normal along z
        directed[0]  = wr_row(0, 0, 0, 0, 0, 0, 16384, 0, 0);
        directed[1]  = wr_row(1, 65536, 0, 0, 0, 0, 16384, 65536, 0);
        directed[2]  = wr_row(2, 0, 65536, 0, 0, 0, 16384, 0, 65536);
        directed[3]  = tri_known(0, 1, 2, 16384, 0, 0, 0, 16384, 0, 0);
        directed[4]  = tri_row(0, 2, 1);                     // negative determinant
        directed[5]  = tri_known(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        // field extremes, saturating deltas
        directed[6]  = wr_row(4095, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                              16'sh8000, 16'sh8000, 16'sh8000, 32'sh8000_0000, 32'sh8000_0000);
        directed[7]  = wr_row(4094, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                              16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        directed[8]  = wr_row(4093, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 16'sh7FFF, 16'sh8000,
                              32'sh7FFF_FFFF, 32'sh8000_0000);
        directed[9]  = tri_row(4095, 4094, 4093);
        directed[10] = tri_row(4093, 4095, 4094);
        // collinear texture coordinates: zero determinant
        directed[11] = wr_row(5, 0, 0, 65536, 16384, 0, 0, 131072, 0);
        directed[12] = tri_known(0, 1, 5, 0, 0, 0, 0, 0, 0, 1);
        // coincident positions: zero-length tangent
        directed[13] = wr_row(7, 0, 0, 0, 0, 16384, 0, 65536, 0);
        directed[14] = wr_row(8, 0, 0, 0, 0, 16384, 0, 0, 65536);
        directed[15] = tri_known(0, 7, 8, 0, 0, 0, 0, 0, 0, 1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            issue_beat(directed[k]);
            maybe_gap(1);
        end

        for (int n = 0; n < NumRandom; n++) begin
            issue_beat(rand_row());
            // hold off once until the pipeline has drained
            if (n == NumRandom / 2) begin
                start <= 1'b0;
                while (pending_corners.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end else begin
                maybe_gap(n < NumRandom - 60);
            end
        end
        start <= 1'b0;

        waited = 0;
        while (pending_corners.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_corners.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* filelist.f */
hdl/ttf_pkg.sv
hdl/triangle_tangent_frame_core.sv
dv/testbench.sv
